// ===== rtl/nrpp_pkg.sv =====
// Shared constants, codes and helpers for the RMC position parser.
package nrpp_pkg;

   localparam int LAT_W        = 56;
   localparam int LON_W        = 64;
   localparam int CHAR_W       = 8;
   localparam int STATUS_W     = 2;
   localparam int COUNT_W      = 7;
   localparam int FIELD_W      = 3;
   localparam int TPOS_W       = 4;
   localparam int TICK_W       = 16;
   localparam int CSR_INDEX_W  = 1;
   localparam int CSR_DATA_W   = 16;

   localparam int LAT_BYTES    = LAT_W / CHAR_W;
   localparam int LON_BYTES    = LON_W / CHAR_W;
   localparam int LAT_CHARS    = 7;
   localparam int LON_CHARS    = 8;

   localparam logic [COUNT_W-1:0] MAX_LEN_RESET = 7'd100;
   localparam logic [TICK_W-1:0]  TIMEOUT_RESET = 16'd1000;
   localparam logic [COUNT_W-1:0] PARSE_LIMIT   = 7'd99;
   localparam logic [COUNT_W-1:0] TAG_LEN       = 7'd6;

   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_SENTENCE_LEN = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT_TICKS    = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_VALID   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_TIMEOUT = 2'd2;

   localparam logic [FIELD_W-1:0] FLD_STATUS = 3'd2;
   localparam logic [FIELD_W-1:0] FLD_LAT    = 3'd3;
   localparam logic [FIELD_W-1:0] FLD_NS     = 3'd4;
   localparam logic [FIELD_W-1:0] FLD_LON    = 3'd5;
   localparam logic [FIELD_W-1:0] FLD_EW     = 3'd6;
   localparam logic [FIELD_W-1:0] FLD_LAST   = 3'd7;
   localparam logic [FIELD_W-1:0] FLD_NEEDED = 3'd6;

   localparam logic [CHAR_W-1:0] CH_DOLLAR = 8'h24;
   localparam logic [CHAR_W-1:0] CH_COMMA  = 8'h2C;
   localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_A      = 8'h41;
   localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;

   // Expected "$GPRMC" prefix character at a given position.
   function automatic logic [CHAR_W-1:0] rmc_tag_char(input logic [2:0] pos);
      logic [CHAR_W-1:0] ch;
      unique case (pos)
         3'd0:    ch = 8'h24;
         3'd1:    ch = 8'h47;
         3'd2:    ch = 8'h50;
         3'd3:    ch = 8'h52;
         3'd4:    ch = 8'h4D;
         3'd5:    ch = 8'h43;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

// ===== rtl/nrpp_ifs.sv =====
// Valid/ready channel interfaces for the byte input and the position result.
interface nrpp_req_if import nrpp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              op;
   logic [CHAR_W-1:0] rx_byte;
   logic              overrun;

   modport source (output valid, output op, output rx_byte, output overrun, input ready);
   modport sink   (input valid, input op, input rx_byte, input overrun, output ready);
endinterface

interface nrpp_rsp_if import nrpp_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [LAT_W-1:0]    latitude_text;
   logic [CHAR_W-1:0]   ns_char;
   logic [LON_W-1:0]    longitude_text;
   logic [CHAR_W-1:0]   ew_char;

   modport source (output valid, output status, output latitude_text, output ns_char,
                   output longitude_text, output ew_char, input ready);
   modport sink   (input valid, input status, input latitude_text, input ns_char,
                   input longitude_text, input ew_char, output ready);
endinterface

// ===== rtl/nmea_rmc_position_parser_core.sv =====
// RMC sentence parser: byte/tick items in, status and held position out.
//
//   channel   dir   handshake      contents
//   req_if    in    valid/ready    op, rx_byte, overrun
//   rsp_if    out   valid/ready    status, latitude_text, ns_char, longitude_text, ew_char
//   csr       in    csr_we         csr_index, csr_wdata
//
// One item per cycle: the parse state updates in the cycle an item is taken.
// A result sits in the output register; a new item is taken while it is held
// unless that register is full and not being drained.
// Synchronous active-high reset clears parse state, held position and the output valid flag.
module nmea_rmc_position_parser_core
   import nrpp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   nrpp_req_if.sink               req_if,
   nrpp_rsp_if.source             rsp_if,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic [COUNT_W-1:0]  cfg_max_len_ff;
   logic [TICK_W-1:0]   cfg_timeout_ff;

   logic                in_sentence_ff, in_sentence_in;
   logic [COUNT_W-1:0]  char_count_ff, char_count_in;
   logic [FIELD_W-1:0]  field_index_ff, field_index_in;
   logic                in_token_ff, in_token_in;
   logic [TPOS_W-1:0]   token_pos_ff, token_pos_in;
   logic                prefix_ok_ff, prefix_ok_in;
   logic                fix_valid_ff, fix_valid_in;
   logic                parse_done_ff, parse_done_in;
   logic [TICK_W-1:0]   tick_count_ff, tick_count_in;
   logic [LAT_W-1:0]    held_lat_ff, held_lat_in;
   logic [CHAR_W-1:0]   held_ns_ff, held_ns_in;
   logic [LON_W-1:0]    held_lon_ff, held_lon_in;
   logic [CHAR_W-1:0]   held_ew_ff, held_ew_in;

   logic                out_valid_ff, out_valid_in;
   logic [STATUS_W-1:0] out_status_ff;
   logic [LAT_W-1:0]    out_lat_ff;
   logic [CHAR_W-1:0]   out_ns_ff;
   logic [LON_W-1:0]    out_lon_ff;
   logic [CHAR_W-1:0]   out_ew_ff;

   logic                accept;
   logic                emit;
   logic [STATUS_W-1:0] emit_status;

   assign req_if.ready = !out_valid_ff || rsp_if.ready;
   assign accept       = req_if.valid && req_if.ready;

   always_comb begin
      logic [CHAR_W-1:0]  c;
      logic [COUNT_W-1:0] limit;
      logic [TICK_W-1:0]  tick_next;
      logic               pfx;
      logic [TPOS_W-1:0]  pos;
      logic [FIELD_W-1:0] fld;
      logic [FIELD_W-1:0] cur;

      c         = req_if.rx_byte;
      limit     = (cfg_max_len_ff == '0) ? '0 : cfg_max_len_ff - 7'd1;
      tick_next = tick_count_ff + 16'd1;
      pfx       = prefix_ok_ff;
      pos       = '0;
      fld       = '0;
      cur       = '0;

      in_sentence_in = in_sentence_ff;
      char_count_in  = char_count_ff;
      field_index_in = field_index_ff;
      in_token_in    = in_token_ff;
      token_pos_in   = token_pos_ff;
      prefix_ok_in   = prefix_ok_ff;
      fix_valid_in   = fix_valid_ff;
      parse_done_in  = parse_done_ff;
      tick_count_in  = tick_count_ff;
      held_lat_in    = held_lat_ff;
      held_ns_in     = held_ns_ff;
      held_lon_in    = held_lon_ff;
      held_ew_in     = held_ew_ff;
      emit           = 1'b0;
      emit_status    = STATUS_INVALID;

      if (accept) begin
         if (req_if.op) begin
            if (cfg_timeout_ff == '0 || tick_next >= cfg_timeout_ff) begin
               emit        = 1'b1;
               emit_status = STATUS_TIMEOUT;
            end else begin
               tick_count_in = tick_next;
            end
         end else if (!req_if.overrun) begin
            if (!in_sentence_ff) begin
               if (c == CH_DOLLAR) begin
                  // '$' opens token one and passes the first prefix check
                  in_sentence_in = 1'b1;
                  char_count_in  = 7'd1;
                  field_index_in = 3'd1;
                  in_token_in    = 1'b1;
                  token_pos_in   = 4'd1;
                  prefix_ok_in   = 1'b1;
                  fix_valid_in   = 1'b0;
                  parse_done_in  = 1'b0;
               end
            end else if (c == CH_LF || char_count_ff >= limit) begin
               emit = 1'b1;
               if (prefix_ok_ff && char_count_ff >= TAG_LEN && fix_valid_ff
                   && field_index_ff >= FLD_NEEDED)
                  emit_status = STATUS_VALID;
            end else if (c != CH_CR) begin
               char_count_in = char_count_ff + 7'd1;
               if (!parse_done_ff && char_count_ff < PARSE_LIMIT) begin
                  if (c == CH_NUL) begin
                     parse_done_in = 1'b1;
                     if (char_count_ff < TAG_LEN)
                        prefix_ok_in = 1'b0;
                  end else begin
                     if (char_count_ff < TAG_LEN && c != rmc_tag_char(char_count_ff[2:0]))
                        pfx = 1'b0;
                     prefix_ok_in = pfx;
                     if (c == CH_COMMA) begin
                        in_token_in = 1'b0;
                     end else if (!in_token_ff && field_index_ff == FLD_LAST) begin
                        parse_done_in = 1'b1;
                     end else begin
                        pos            = in_token_ff ? token_pos_ff : '0;
                        fld            = in_token_ff ? field_index_ff : field_index_ff + 3'd1;
                        cur            = fld - 3'd1;
                        in_token_in    = 1'b1;
                        field_index_in = fld;
                        token_pos_in   = (pos == 4'd15) ? pos : pos + 4'd1;
                        if (pfx) begin
                           if (cur == FLD_STATUS && pos == '0) begin
                              fix_valid_in = (c == CH_A);
                           end else if (cur == FLD_LAT && fix_valid_ff) begin
                              if (pos == '0)
                                 held_lat_in = '0;
                              for (int k = 0; k < LAT_BYTES; k++) begin
                                 if (k < LAT_CHARS && pos == TPOS_W'(k))
                                    held_lat_in[LAT_W-CHAR_W-CHAR_W*k +: CHAR_W] = c;
                              end
                           end else if (cur == FLD_NS && fix_valid_ff && pos == '0) begin
                              held_ns_in = c;
                           end else if (cur == FLD_LON && fix_valid_ff) begin
                              if (pos == '0)
                                 held_lon_in = '0;
                              for (int k = 0; k < LON_BYTES; k++) begin
                                 if (k < LON_CHARS && pos == TPOS_W'(k))
                                    held_lon_in[LON_W-CHAR_W-CHAR_W*k +: CHAR_W] = c;
                              end
                           end else if (cur == FLD_EW && fix_valid_ff && pos == '0) begin
                              held_ew_in = c;
                           end
                        end
                     end
                  end
               end
            end
         end

         if (emit) begin
            in_sentence_in = 1'b0;
            tick_count_in  = '0;
            char_count_in  = '0;
            field_index_in = '0;
            in_token_in    = 1'b0;
            token_pos_in   = '0;
            prefix_ok_in   = 1'b1;
            fix_valid_in   = 1'b0;
            parse_done_in  = 1'b0;
         end
      end
   end

   always_comb begin
      if (accept && emit)
         out_valid_in = 1'b1;
      else if (rsp_if.ready)
         out_valid_in = 1'b0;
      else
         out_valid_in = out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_max_len_ff <= MAX_LEN_RESET;
         cfg_timeout_ff <= TIMEOUT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MAX_SENTENCE_LEN: cfg_max_len_ff <= csr_wdata[COUNT_W-1:0];
            CSR_TIMEOUT_TICKS:    cfg_timeout_ff <= csr_wdata[TICK_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_sentence_ff <= 1'b0;
         char_count_ff  <= '0;
         field_index_ff <= '0;
         in_token_ff    <= 1'b0;
         token_pos_ff   <= '0;
         prefix_ok_ff   <= 1'b1;
         fix_valid_ff   <= 1'b0;
         parse_done_ff  <= 1'b0;
         tick_count_ff  <= '0;
         held_lat_ff    <= '0;
         held_ns_ff     <= '0;
         held_lon_ff    <= '0;
         held_ew_ff     <= '0;
         out_valid_ff   <= 1'b0;
      end else begin
         in_sentence_ff <= in_sentence_in;
         char_count_ff  <= char_count_in;
         field_index_ff <= field_index_in;
         in_token_ff    <= in_token_in;
         token_pos_ff   <= token_pos_in;
         prefix_ok_ff   <= prefix_ok_in;
         fix_valid_ff   <= fix_valid_in;
         parse_done_ff  <= parse_done_in;
         tick_count_ff  <= tick_count_in;
         held_lat_ff    <= held_lat_in;
         held_ns_ff     <= held_ns_in;
         held_lon_ff    <= held_lon_in;
         held_ew_ff     <= held_ew_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   // result payload is loaded with the held values as they stand before the item
   always_ff @(posedge clock) begin
      if (accept && emit) begin
         out_status_ff <= emit_status;
         out_lat_ff    <= held_lat_ff;
         out_ns_ff     <= held_ns_ff;
         out_lon_ff    <= held_lon_ff;
         out_ew_ff     <= held_ew_ff;
      end
   end

   assign rsp_if.valid          = out_valid_ff;
   assign rsp_if.status         = out_status_ff;
   assign rsp_if.latitude_text  = out_lat_ff;
   assign rsp_if.ns_char        = out_ns_ff;
   assign rsp_if.longitude_text = out_lon_ff;
   assign rsp_if.ew_char        = out_ew_ff;

endmodule

// ===== tb/nmea_rmc_position_parser_core_tb.sv =====
// Testbench for the RMC position parser: random sentences, ticks and noise against a predictor.
`timescale 1ns / 1ps

module nmea_rmc_position_parser_core_tb;
   import nrpp_pkg::*;

   typedef enum logic {OP_BYTE = 1'b0, OP_TICK = 1'b1} item_op_type;

   typedef struct packed {
      item_op_type       op;
      logic [CHAR_W-1:0] ch;
      logic              ovr;
   } serial_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [LAT_W-1:0]    lat;
      logic [CHAR_W-1:0]   ns;
      logic [LON_W-1:0]    lon;
      logic [CHAR_W-1:0]   ew;
   } fix_type;

   localparam int SETTLE_CYCLES  = 10;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int ITEM_TARGET    = 750;
   localparam int FIX_TARGET     = 60;
   localparam int MAX_STALL      = 10;
   localparam int N_PHASES       = 9;

   localparam int PH_LEN  [N_PHASES] = '{100, 2, 127, 0, 1, 40, 12, 100, 64};
   localparam int PH_TMO  [N_PHASES] = '{1000, 65535, 1000, 30, 0, 200, 6, 65535, 1};
   localparam int PH_TICK [N_PHASES] = '{2, 0, 1, 8, 3, 4, 10, 0, 1};

   localparam logic [CHAR_W-1:0] RMC_TAG [0:5] = '{8'h24, 8'h47, 8'h50, 8'h52, 8'h4D, 8'h43};
   localparam logic [CHAR_W-1:0] CH_DOT = 8'h2E;

   logic clock;
   logic reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   nrpp_req_if req_bus ();
   nrpp_rsp_if rsp_bus ();

   nmea_rmc_position_parser_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_bus),
      .rsp_if    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // predictor state
   logic [COUNT_W-1:0]  cfg_len     = MAX_LEN_RESET;
   logic [TICK_W-1:0]   cfg_timeout = TIMEOUT_RESET;
   logic                sent_active = 1'b0;
   int                  stored_cnt  = 0;
   int                  tok_cnt     = 0;
   logic                tok_open    = 1'b0;
   int                  tok_pos     = 0;
   logic                tag_match   = 1'b1;
   logic                fix_ok      = 1'b0;
   logic                parse_stop  = 1'b0;
   logic [TICK_W-1:0]   ticks       = '0;
   logic [LAT_W-1:0]    lat_hold    = '0;
   logic [CHAR_W-1:0]   ns_hold     = '0;
   logic [LON_W-1:0]    lon_hold    = '0;
   logic [CHAR_W-1:0]   ew_hold     = '0;

   fix_type    pending_fixes[$];
   serial_type serial_backlog[$];
   logic [CHAR_W-1:0] line_buf[$];

   int   queued_cnt     = 0;
   int   taken_cnt      = 0;
   int   sentence_items = 0;
   int   fix_count      = 0;
   int   errors         = 0;
   int   quiet_cycles   = 0;
   logic req_taken      = 1'b0;
   logic rsp_taken      = 1'b0;
   logic pacing_on      = 1'b1;
   logic hold_req       = 1'b0;
   logic hold_done      = 1'b0;
   int   hold_left      = 0;
   int   gap_left       = 0;
   int   stall_left     = 0;
   serial_type drv_item;

   function automatic void restart_parse();
      stored_cnt = 0;
      tok_cnt    = 0;
      tok_open   = 1'b0;
      tok_pos    = 0;
      tag_match  = 1'b1;
      fix_ok     = 1'b0;
      parse_stop = 1'b0;
   endfunction

   function automatic void latch_fix(input logic [STATUS_W-1:0] st);
      fix_type f;
      f.status = st;
      f.lat    = lat_hold;
      f.ns     = ns_hold;
      f.lon    = lon_hold;
      f.ew     = ew_hold;
      pending_fixes.push_back(f);
      sent_active = 1'b0;
      ticks       = '0;
      restart_parse();
   endfunction

   function automatic void scan_char(input int idx, input logic [CHAR_W-1:0] c);
      int slot;
      if (parse_stop || idx >= int'(PARSE_LIMIT)) return;
      if (c == CH_NUL) begin
         parse_stop = 1'b1;
         if (idx < int'(TAG_LEN)) tag_match = 1'b0;
         return;
      end
      if (idx < int'(TAG_LEN) && c != RMC_TAG[idx]) tag_match = 1'b0;
      if (c == CH_COMMA) begin
         tok_open = 1'b0;
         return;
      end
      if (!tok_open) begin
         if (tok_cnt >= int'(FLD_LAST)) begin
            parse_stop = 1'b1;
            return;
         end
         tok_open = 1'b1;
         tok_pos  = 0;
         tok_cnt++;
      end
      slot = tok_cnt - 1;
      if (tag_match) begin
         if (slot == int'(FLD_STATUS) && tok_pos == 0) begin
            fix_ok = (c == CH_A);
         end else if (slot == int'(FLD_LAT) && fix_ok) begin
            if (tok_pos == 0) lat_hold = '0;
            if (tok_pos < LAT_CHARS)
               lat_hold |= LAT_W'(c) << (CHAR_W * (LAT_CHARS - 1 - tok_pos));
         end else if (slot == int'(FLD_NS) && fix_ok && tok_pos == 0) begin
            ns_hold = c;
         end else if (slot == int'(FLD_LON) && fix_ok) begin
            if (tok_pos == 0) lon_hold = '0;
            if (tok_pos < LON_CHARS)
               lon_hold |= LON_W'(c) << (CHAR_W * (LON_CHARS - 1 - tok_pos));
         end else if (slot == int'(FLD_EW) && fix_ok && tok_pos == 0) begin
            ew_hold = c;
         end
      end
      if (tok_pos < 15) tok_pos++;
   endfunction

   function automatic void parse_rmc_item(input serial_type it);
      int   lim;
      logic good;
      if (it.op == OP_TICK) begin
         ticks = ticks + 1'b1;
         if (cfg_timeout == 0 || ticks >= cfg_timeout) latch_fix(STATUS_TIMEOUT);
         return;
      end
      if (it.ovr) return;
      if (!sent_active) begin
         if (it.ch == CH_DOLLAR) begin
            sent_active = 1'b1;
            restart_parse();
            scan_char(0, it.ch);
            stored_cnt = 1;
         end
         return;
      end
      lim = (cfg_len == 0) ? 0 : int'(cfg_len) - 1;
      if (it.ch == CH_LF || stored_cnt >= lim) begin
         good = tag_match && stored_cnt >= int'(TAG_LEN) && fix_ok
                && tok_cnt >= int'(FLD_NEEDED);
         latch_fix(good ? STATUS_VALID : STATUS_INVALID);
         return;
      end
      if (it.ch != CH_CR) begin
         scan_char(stored_cnt, it.ch);
         stored_cnt = (stored_cnt + 1) & 127;
      end
   endfunction

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
         errors++;
      end
   endfunction

   function automatic void offer(input item_op_type op, input logic [CHAR_W-1:0] ch,
                                 input logic ovr);
      serial_type it;
      it.op  = op;
      it.ch  = ch;
      it.ovr = ovr;
      serial_backlog.push_back(it);
      queued_cnt++;
   endfunction

   function automatic void put_str(input string s);
      foreach (s[i]) line_buf.push_back(s[i]);
   endfunction

   function automatic void put_digits(input int n);
      repeat (n) begin
         if ($urandom_range(0, 10) == 10) line_buf.push_back(CH_DOT);
         else line_buf.push_back(8'(48 + $urandom_range(0, 9)));
      end
   endfunction

   // one sentence attempt, mostly well formed, with noise, overruns and ticks mixed in
   task automatic queue_sentence(input int tick_pct);
      int kind;
      line_buf.delete();
      kind = $urandom_range(0, 11);
      if (kind == 0) begin
         put_str("$");
         case ($urandom_range(0, 2))
            0:       line_buf.push_back(CH_CR);
            1:       line_buf.push_back(CH_LF);
            default: line_buf.push_back(8'($urandom));
         endcase
      end else begin
         if (kind == 1) put_str("$GPGGA");
         else if (kind == 2) put_str("$GP");
         else put_str("$GPRMC");
         put_str(",");
         put_digits(($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 9));
         put_str(",");
         if ($urandom_range(0, 4) != 0) line_buf.push_back(CH_A);
         else line_buf.push_back(8'($urandom_range(1, 255)));
         put_str(",");
         put_digits($urandom_range(0, 10));
         put_str($urandom_range(0, 1) ? ",N," : ",S,");
         put_digits($urandom_range(0, 11));
         put_str($urandom_range(0, 1) ? ",E" : ",W");
         repeat ($urandom_range(0, 3)) begin
            put_str(",");
            put_digits($urandom_range(0, 6));
         end
         if ($urandom_range(0, 9) == 0) put_digits($urandom_range(60, 110));
         if (kind == 3) line_buf.insert($urandom_range(1, line_buf.size() - 1), CH_NUL);
         if (kind == 4) line_buf.insert($urandom_range(1, line_buf.size() - 1), CH_CR);
         if (kind == 5) line_buf[$urandom_range(1, line_buf.size() - 1)] = 8'($urandom);
      end
      case ($urandom_range(0, 6))
         0:       ;
         1:       put_str("\n");
         default: put_str("\r\n");
      endcase
      if ($urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 3)) offer(OP_BYTE, 8'($urandom), 1'b0);
      foreach (line_buf[i]) begin
         if ($urandom_range(0, 29) == 0) offer(OP_BYTE, 8'($urandom), 1'b1);
         if ($urandom_range(0, 99) < tick_pct) begin
            offer(OP_TICK, 8'($urandom), 1'($urandom));
            sentence_items++;
         end
         offer(OP_BYTE, line_buf[i], 1'b0);
         sentence_items++;
      end
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_MAX_SENTENCE_LEN) cfg_len = data[COUNT_W-1:0];
      else cfg_timeout = data[TICK_W-1:0];
   endtask

   task automatic settle();
      while (taken_cnt != queued_cnt || pending_fixes.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // sender
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         gap_left = 0;
      end else if (!req_bus.valid || req_taken) begin
         if (gap_left > 0) begin
            req_bus.valid <= 1'b0;
            gap_left--;
         end else if (serial_backlog.size() != 0) begin
            drv_item = serial_backlog.pop_front();
            req_bus.valid   <= 1'b1;
            req_bus.op      <= drv_item.op;
            req_bus.rx_byte <= drv_item.ch;
            req_bus.overrun <= drv_item.ovr;
            gap_left = pacing_on ? $urandom_range(0, MAX_STALL) : 0;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // receiver
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left = 0;
      end else if (hold_left > 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left--;
      end else if (hold_req && !hold_done) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_taken) stall_left = pacing_on ? $urandom_range(0, MAX_STALL) : 0;
         if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // monitor, checker and watchdog
   always @(posedge clock) begin : monitor
      serial_type seen;
      fix_type    want;
      if (reset) begin
         req_taken <= 1'b0;
         rsp_taken <= 1'b0;
      end else begin
         req_taken <= req_bus.valid && req_bus.ready;
         rsp_taken <= rsp_bus.valid && rsp_bus.ready;
         if (req_bus.valid && req_bus.ready) begin
            seen.op  = item_op_type'(req_bus.op);
            seen.ch  = req_bus.rx_byte;
            seen.ovr = req_bus.overrun;
            parse_rmc_item(seen);
            taken_cnt++;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            fix_count++;
            if (pending_fixes.size() == 0) begin
               $display("%0t: result with none expected: expected nothing, got status %0d",
                        $time, rsp_bus.status);
               errors++;
            end else begin
               want = pending_fixes.pop_front();
               check_field("status", 64'(want.status), 64'(rsp_bus.status));
               check_field("latitude_text", 64'(want.lat), 64'(rsp_bus.latitude_text));
               check_field("ns_char", 64'(want.ns), 64'(rsp_bus.ns_char));
               check_field("longitude_text", want.lon, rsp_bus.longitude_text);
               check_field("ew_char", 64'(want.ew), 64'(rsp_bus.ew_char));
            end
         end
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int phase;
      int len_val;
      int tmo_val;
      int tick_pct;
      int phase_start;
      reset           = 1'b1;
      csr_we          = 1'b0;
      csr_index       = '0;
      csr_wdata       = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: a minimal valid fix, overrun, tick, zero byte in a short sentence
      line_buf.delete();
      put_str("$GPRMC,1,A,2,N,3,E\r\n");
      foreach (line_buf[i]) offer(OP_BYTE, line_buf[i], 1'b0);
      offer(OP_BYTE, 8'hFF, 1'b1);
      offer(OP_TICK, CH_NUL, 1'b0);
      offer(OP_BYTE, CH_DOLLAR, 1'b0);
      offer(OP_BYTE, CH_NUL, 1'b0);
      offer(OP_BYTE, CH_LF, 1'b0);
      settle();

      // output held off while every tick times out, so the input backs up
      write_csr(CSR_MAX_SENTENCE_LEN, 16'd100);
      write_csr(CSR_TIMEOUT_TICKS, 16'd1);
      hold_req = 1'b1;
      repeat (40) offer(OP_TICK, 8'($urandom), 1'($urandom));
      settle();

      phase = 0;
      while (sentence_items < ITEM_TARGET || fix_count < FIX_TARGET) begin
         if (phase < N_PHASES) begin
            len_val  = PH_LEN[phase];
            tmo_val  = PH_TMO[phase];
            tick_pct = PH_TICK[phase];
         end else begin
            len_val  = $urandom_range(2, 100);
            tmo_val  = $urandom_range(1, 400);
            tick_pct = $urandom_range(0, 6);
         end
         write_csr(CSR_MAX_SENTENCE_LEN, 16'(len_val));
         write_csr(CSR_TIMEOUT_TICKS, 16'(tmo_val));
         pacing_on = ($urandom_range(0, 2) != 0);
         phase_start = sentence_items;
         while (sentence_items - phase_start < 90) queue_sentence(tick_pct);
         settle();
         phase++;
      end

      settle();
      if (errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// ===== nmea_rmc_position_parser_core.f =====
rtl/nrpp_pkg.sv
rtl/nrpp_ifs.sv
rtl/nmea_rmc_position_parser_core.sv
tb/nmea_rmc_position_parser_core_tb.sv
